// ----- hdl/swbm_pkg.sv -----
// Package for the sliding window bandwidth meter.
// Holds widths, the ring depth, and the controller/datapath command and status types.
package swbm_pkg;

    localparam int RING_DEPTH = 256;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int BYTE_W     = 24;
    localparam int TIME_W     = 48;
    localparam int RATE_W     = 40;
    localparam int WIN_W      = 12;
    localparam int EXCL_W     = 24;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int USEC_W     = 20;
    localparam int TOT_W      = BYTE_W + IDX_W + 1;
    localparam int FRAC_SH    = 19;
    localparam int QUO_W      = TOT_W + FRAC_SH;
    localparam int DCNT_W     = $clog2(QUO_W + 1);

    localparam logic [USEC_W-1:0]    USEC_PER_SEC = USEC_W'(1000000);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXCL     = 1'b1;
    localparam logic [WIN_W-1:0]     WINDOW_RST   = WIN_W'(30);
    localparam logic [EXCL_W-1:0]    EXCL_RST     = EXCL_W'(500000);
    localparam logic [RATE_W-1:0]    RATE_MAX     = {RATE_W{1'b1}};
    localparam logic                 ACT_ADD      = 1'b0;

    typedef struct packed {
        logic load;
        logic exp_rd;
        logic exp_ck;
        logic scan_init;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic commit;
        logic out_load;
    } swbm_cmd_t;

    typedef struct packed {
        logic empty;
        logic expired;
        logic scan_done;
        logic div_done;
        logic out_free;
    } swbm_stat_t;

endpackage

// ----- hdl/swbm_if.sv -----
// Channel interfaces of the sliding window bandwidth meter.
// Depends on swbm_pkg for the field widths.
interface swbm_in_if;
    import swbm_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [TIME_W-1:0] timestamp_us;
    logic [BYTE_W-1:0] byte_count;
    modport source (output valid, action, timestamp_us, byte_count, input ready);
    modport sink (input valid, action, timestamp_us, byte_count, output ready);
endinterface

interface swbm_out_if;
    import swbm_pkg::*;
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] average_rate;
    logic [RATE_W-1:0] peak_rate;
    logic              dropped_oldest;
    modport source (output valid, average_rate, peak_rate, dropped_oldest, input ready);
    modport sink (input valid, average_rate, peak_rate, dropped_oldest, output ready);
endinterface

// ----- hdl/swbm_ctrl.sv -----
// Controller state machine of the bandwidth meter.
// Sequences expiry, ring scan, division and commit; depends on swbm_pkg.
module swbm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  swbm_pkg::swbm_stat_t stat,
    output swbm_pkg::swbm_cmd_t  cmd
);
    import swbm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXP_RD = 7'b0000010,
        S_EXP_CK = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_RD:
            begin
                if (stat.empty)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    cmd.exp_rd = 1'b1;
                    state_next = S_EXP_CK;
                end
            end
            S_EXP_CK:
            begin
                cmd.exp_ck = 1'b1;
                if (stat.expired)
                begin
                    state_next = S_EXP_RD;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/swbm_dp.sv -----
// Datapath of the bandwidth meter: ring memories, expiry and scan logic,
// serial divider and result registers. Depends on swbm_pkg.
module swbm_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  swbm_pkg::swbm_cmd_t              cmd,
    output swbm_pkg::swbm_stat_t             stat,
    input  logic                             cfg_we,
    input  logic [swbm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swbm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_action,
    input  logic [swbm_pkg::TIME_W-1:0]      in_time,
    input  logic [swbm_pkg::BYTE_W-1:0]      in_bytes,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [swbm_pkg::RATE_W-1:0]      out_avg,
    output logic [swbm_pkg::RATE_W-1:0]      out_peak,
    output logic                             out_drop
);
    import swbm_pkg::*;

    logic [TIME_W-1:0] time_mem [RING_DEPTH];
    logic [BYTE_W-1:0] bytes_mem [RING_DEPTH];
    logic [RATE_W-1:0] avg_mem [RING_DEPTH];

    logic [WIN_W-1:0]  window_reg;
    logic [EXCL_W-1:0] excl_reg;
    logic [TIME_W-1:0] limit_reg;

    logic              action_reg;
    logic [TIME_W-1:0] now_reg;
    logic [BYTE_W-1:0] bytes_reg;

    logic [IDX_W-1:0]  oldest_reg;
    logic [CNT_W-1:0]  total_reg;

    logic [TIME_W-1:0] time_q_reg;
    logic [BYTE_W-1:0] bytes_q_reg;
    logic [RATE_W-1:0] avg_q_reg;

    logic [CNT_W-1:0]  k_reg;
    logic              pend_reg;
    logic              kfirst_reg;
    logic [TOT_W-1:0]  sum_reg;
    logic              have_first_reg;
    logic [TIME_W-1:0] first_reg;
    logic [RATE_W-1:0] peak_reg;

    logic [QUO_W-1:0]  quo_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] dvs_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              zero_reg;

    logic [RATE_W-1:0] res_avg_reg;
    logic [RATE_W-1:0] res_peak_reg;
    logic              res_drop_reg;
    logic              out_valid_reg;
    logic [RATE_W-1:0] out_avg_reg;
    logic [RATE_W-1:0] out_peak_reg;
    logic              out_drop_reg;

    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] age;
    logic              age_pos;
    logic              counted;
    logic              drop_now;
    logic              skip_peak;
    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   rem_sub;
    logic [RATE_W-1:0] avg_sat;
    logic              full;
    logic [IDX_W-1:0]  oldest_n;
    logic [CNT_W-1:0]  total_n;
    logic [IDX_W-1:0]  wr_slot;

    assign rd_addr   = cmd.scan_step ? IDX_W'(oldest_reg + k_reg[IDX_W-1:0]) : oldest_reg;
    assign age_pos   = now_reg > time_q_reg;
    assign age       = now_reg - time_q_reg;
    assign counted   = age_pos && (age > TIME_W'(excl_reg));
    assign full      = (total_reg == CNT_W'(RING_DEPTH));
    assign drop_now  = (action_reg == ACT_ADD) && full;
    assign skip_peak = drop_now && kfirst_reg;
    assign rem_sh    = {rem_reg, quo_reg[QUO_W-1]};
    assign rem_sub   = rem_sh - {1'b0, dvs_reg};
    assign avg_sat   = zero_reg ? '0 :
                       ((|quo_reg[QUO_W-1:RATE_W]) ? RATE_MAX : quo_reg[RATE_W-1:0]);
    assign oldest_n  = drop_now ? IDX_W'(oldest_reg + 1'b1) : oldest_reg;
    assign total_n   = drop_now ? CNT_W'(total_reg - 1'b1) : total_reg;
    assign wr_slot   = IDX_W'(oldest_n + total_n[IDX_W-1:0]);

    assign stat.empty     = (total_reg == '0);
    assign stat.expired   = age_pos && (age > limit_reg);
    assign stat.scan_done = (k_reg == total_reg) && !pend_reg;
    assign stat.div_done  = (dcnt_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        time_q_reg  <= time_mem[rd_addr];
        bytes_q_reg <= bytes_mem[rd_addr];
        avg_q_reg   <= avg_mem[rd_addr];
        if (cmd.commit && (action_reg == ACT_ADD))
        begin
            time_mem[wr_slot]  <= now_reg;
            bytes_mem[wr_slot] <= bytes_reg;
            avg_mem[wr_slot]   <= avg_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg <= TIME_W'(window_reg) * TIME_W'(USEC_PER_SEC);
        if (cmd.load)
        begin
            action_reg <= in_action;
            now_reg    <= in_time;
            bytes_reg  <= in_bytes;
        end
        if (cmd.scan_init)
        begin
            sum_reg        <= '0;
            have_first_reg <= 1'b0;
            first_reg      <= '0;
            peak_reg       <= '0;
            kfirst_reg     <= 1'b1;
        end
        else if (cmd.scan_step)
        begin
            kfirst_reg <= (k_reg == '0);
            if (pend_reg)
            begin
                if (counted)
                begin
                    sum_reg <= sum_reg + TOT_W'(bytes_q_reg);
                    if (!have_first_reg)
                    begin
                        have_first_reg <= 1'b1;
                        first_reg      <= time_q_reg;
                    end
                end
                if (!skip_peak && (avg_q_reg > peak_reg))
                begin
                    peak_reg <= avg_q_reg;
                end
            end
        end
        if (cmd.div_init)
        begin
            quo_reg  <= {sum_reg, FRAC_SH'(0)};
            rem_reg  <= '0;
            dvs_reg  <= now_reg - first_reg;
            zero_reg <= (sum_reg == '0) || !have_first_reg;
        end
        else if (cmd.div_step)
        begin
            if (!rem_sub[TIME_W])
            begin
                rem_reg <= rem_sub[TIME_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[TIME_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.commit)
        begin
            res_avg_reg  <= avg_sat;
            res_drop_reg <= drop_now;
            if ((action_reg == ACT_ADD) && (avg_sat > peak_reg))
            begin
                res_peak_reg <= avg_sat;
            end
            else
            begin
                res_peak_reg <= peak_reg;
            end
        end
        if (cmd.out_load)
        begin
            out_avg_reg  <= res_avg_reg;
            out_peak_reg <= res_peak_reg;
            out_drop_reg <= res_drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RST;
            excl_reg      <= EXCL_RST;
            oldest_reg    <= '0;
            total_reg     <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                    REG_EXCL:   excl_reg   <= cfg_data[EXCL_W-1:0];
                    default:    ;
                endcase
            end
            if (cmd.exp_ck && stat.expired)
            begin
                oldest_reg <= IDX_W'(oldest_reg + 1'b1);
                total_reg  <= CNT_W'(total_reg - 1'b1);
            end
            else if (cmd.commit && (action_reg == ACT_ADD))
            begin
                oldest_reg <= oldest_n;
                total_reg  <= CNT_W'(total_n + 1'b1);
            end
            if (cmd.scan_init)
            begin
                k_reg    <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (k_reg != total_reg)
                begin
                    k_reg    <= CNT_W'(k_reg + 1'b1);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.div_init)
            begin
                dcnt_reg <= DCNT_W'(QUO_W);
            end
            else if (cmd.div_step)
            begin
                dcnt_reg <= DCNT_W'(dcnt_reg - 1'b1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_avg   = out_avg_reg;
    assign out_peak  = out_peak_reg;
    assign out_drop  = out_drop_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CNT_W'(RING_DEPTH))
        else $error("Ring fill count exceeds the depth.");

    a_drop_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && drop_now) |=> (total_reg == CNT_W'(RING_DEPTH)))
        else $error("A commit that dropped an entry did not leave the ring full.");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= DCNT_W'(QUO_W))
        else $error("Divider step count out of range.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (k_reg <= total_reg))
        else $error("Scan index ran past the fill count.");

endmodule

// ----- hdl/sliding_window_bandwidth_meter.sv -----
// Top level of the sliding window bandwidth meter.
// Depends on swbm_pkg, swbm_if, swbm_ctrl and swbm_dp.
//
// One input word is taken at a time; ready is high only while the block is idle.
// Expiry reads and then checks the oldest ring entry in turn, the scan reads one
// entry per cycle, and the rate is found by a one-bit-per-cycle divider over 52
// quotient bits. The next word is accepted while a finished result still waits on
// the output register.
module sliding_window_bandwidth_meter (
    input  logic                           clk,
    input  logic                           rst_n,
    swbm_in_if.sink                        in_ch,
    swbm_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [swbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swbm_pkg::CFG_W-1:0]     cfg_data
);
    import swbm_pkg::*;

    swbm_cmd_t  cmd;
    swbm_stat_t stat;

    swbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    swbm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (in_ch.action),
        .in_time   (in_ch.timestamp_us),
        .in_bytes  (in_ch.byte_count),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_avg   (out_ch.average_rate),
        .out_peak  (out_ch.peak_rate),
        .out_drop  (out_ch.dropped_oldest)
    );

endmodule
